[rtl/core/lsbne_pkg.sv]
// Shared types and constants of the LED strip BCD number encoder.
`default_nettype none
package lsbne_pkg;

  localparam int NUM_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int SPI_W       = 64;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = 6;
  localparam int CONV_STEPS  = 5;
  localparam int STEP_W      = 3;
  localparam int PIX_W       = 5;
  localparam int COMP_W      = 2;
  localparam int RECIP_SHIFT = 19;

  localparam logic [NUM_W-1:0]  RECIP10   = 16'd52429;
  localparam logic [BYTE_W-1:0] CODE_ONE  = 8'h3F;
  localparam logic [BYTE_W-1:0] CODE_ZERO = 8'h38;
  localparam logic [BYTE_W-1:0] DIM_LEVEL = 8'h01;

  localparam logic [COMP_W-1:0] COMP_G = 2'd0;
  localparam logic [COMP_W-1:0] COMP_R = 2'd1;
  localparam logic [COMP_W-1:0] COMP_B = 2'd2;

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

  typedef struct packed {
    logic       valid;
    digit_vec_t digits;
  } conv_out_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BYTE_W-1:0] data;
  } pix_byte_t;

endpackage
`default_nettype wire

[rtl/core/lsbne_if.sv]
// Valid/ready channel interfaces for numbers in and SPI code words out.
`default_nettype none
interface lsbne_in_if;
  import lsbne_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface lsbne_out_if;
  import lsbne_pkg::*;

  logic             valid;
  logic             ready;
  logic [SPI_W-1:0] spi_codes;
  logic             last;

  modport source (output valid, output spi_codes, output last, input ready);
  modport sink   (input valid, input spi_codes, input last, output ready);
endinterface
`default_nettype wire

[rtl/core/led_strip_bcd_number_encoder.sv]
// Top level of the LED strip BCD number encoder.
// Each accepted number yields 3*PIXEL_COUNT result items (48 at the default),
// one per cycle unless the output stalls, last set on the final one. The number
// is split into decimal digits by an iterative divide-by-ten unit, which runs
// while the previous number's items are still going out; the output word
// stream sets the sustained number rate, except on strips under three pixels,
// where the accept, convert and load loop does.
// The output passes through a sequencer stage, a pixel byte stage and a code
// register; a stall holds all three. brightness (reset 255) is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this.
`default_nettype none
module led_strip_bcd_number_encoder #(
  parameter int PIXEL_COUNT = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  lsbne_in_if.sink        in_ch,
  lsbne_out_if.source     out_ch
);
  import lsbne_pkg::*;

  logic [BYTE_W-1:0] brightness_r;
  conv_out_t         conv;
  pix_byte_t         fbyte;
  logic              take;
  logic              adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 8'hFF;
    end else if (cfg_we) begin
      brightness_r <= cfg_wdata;
    end
  end

  lsbne_digit_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .conv  (conv)
  );

  lsbne_frame_seq #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .brightness (brightness_r),
    .adv        (adv),
    .conv       (conv),
    .take       (take),
    .fbyte      (fbyte)
  );

  lsbne_code_expand u_expand (
    .clk    (clk),
    .rst_n  (rst_n),
    .fbyte  (fbyte),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/lsbne_digit_conv.sv]
// Iterative binary to decimal digit converter, one digit per cycle.
`default_nettype none
module lsbne_digit_conv (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lsbne_in_if.sink           in_ch,
  input  wire logic          take,
  output lsbne_pkg::conv_out_t conv
);
  import lsbne_pkg::*;

  logic              busy_r, busy_nxt;
  logic              full_r, full_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  v_r;
  digit_vec_t        digits_r;

  logic [2*NUM_W-1:0] prod;
  logic [NUM_W-1:0]   quot;
  logic [NUM_W-1:0]   quot10;
  logic [NUM_W-1:0]   rem;
  logic               accept;

  assign in_ch.ready = !busy_r && !full_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // floor(v/10) by reciprocal, exact for 16-bit v
  assign prod   = (2*NUM_W)'(v_r) * (2*NUM_W)'(RECIP10);
  assign quot   = NUM_W'(prod >> RECIP_SHIFT);
  assign quot10 = {quot[NUM_W-4:0], 3'b000} + {quot[NUM_W-2:0], 1'b0};
  assign rem    = v_r - quot10;

  always_comb begin
    busy_nxt = busy_r;
    full_nxt = full_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (step_r == STEP_W'(CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        full_nxt = 1'b1;
      end
      step_nxt = step_r + STEP_W'(1);
    end else if (take) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      full_r <= full_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r                <= in_ch.number;
      digits_r[DIGITS-1] <= '0;
    end else if (busy_r) begin
      v_r              <= quot;
      digits_r[step_r] <= rem[DIGIT_W-1:0];
    end
  end

  assign conv.valid  = full_r;
  assign conv.digits = digits_r;

endmodule
`default_nettype wire

[rtl/core/lsbne_frame_seq.sv]
// Frame byte sequencer and pixel byte stage.
`default_nettype none
module lsbne_frame_seq #(
  parameter int PIXEL_COUNT = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           brightness,
  input  wire logic                 adv,
  input  wire lsbne_pkg::conv_out_t conv,
  output logic                      take,
  output lsbne_pkg::pix_byte_t      fbyte
);
  import lsbne_pkg::*;

  logic              active_r;
  logic [PIX_W-1:0]  pix_r;
  logic [COMP_W-1:0] comp_r;
  digit_vec_t        digits_r;

  logic              s2_valid_r;
  logic              s2_last_r;
  logic [BYTE_W-1:0] s2_data_r;

  logic              s1_last;
  logic              s1_fire;
  logic              upper;
  logic [2:0]        dig_idx;
  logic [DIGIT_W-1:0] digit;
  logic              bit_set;
  logic [BYTE_W-1:0] byte_val;

  assign s1_last = (pix_r == PIX_W'(PIXEL_COUNT - 1)) && (comp_r == COMP_B);
  assign s1_fire = adv && active_r;
  assign take    = conv.valid && (!active_r || (s1_fire && s1_last));

  assign upper   = pix_r[2];
  assign dig_idx = {pix_r[4:3], upper};
  assign digit   = digits_r[dig_idx];
  assign bit_set = digit[pix_r[1:0]];

  always_comb begin
    case (comp_r)
      COMP_G:  byte_val = bit_set ? (upper ? '0 : brightness) : (upper ? '0 : DIM_LEVEL);
      COMP_R:  byte_val = bit_set ? '0 : DIM_LEVEL;
      COMP_B:  byte_val = bit_set ? (upper ? brightness : '0) : DIM_LEVEL;
      default: byte_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pix_r    <= '0;
      comp_r   <= COMP_G;
    end else if (take) begin
      active_r <= 1'b1;
      pix_r    <= '0;
      comp_r   <= COMP_G;
    end else if (s1_fire) begin
      if (s1_last) begin
        active_r <= 1'b0;
      end else if (comp_r == COMP_B) begin
        comp_r <= COMP_G;
        pix_r  <= pix_r + PIX_W'(1);
      end else begin
        comp_r <= comp_r + COMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digits_r <= conv.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_last;
      s2_data_r <= byte_val;
    end
  end

  assign fbyte.valid = s2_valid_r;
  assign fbyte.last  = s2_last_r;
  assign fbyte.data  = s2_data_r;

`ifndef SYNTHESIS
  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pix_r <= PIX_W'(PIXEL_COUNT - 1)) && (comp_r != 2'd3))
    else $error("pixel counter out of frame");

  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_last |=> active_r)
    else $error("frame ended early");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s2_valid_r) && $stable(s2_data_r) && $stable(s2_last_r))
    else $error("byte stage changed during stall");
`endif

endmodule
`default_nettype wire

[rtl/core/lsbne_code_expand.sv]
// Expands frame bytes into SPI line codes and holds the output register.
`default_nettype none
module lsbne_code_expand (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lsbne_pkg::pix_byte_t fbyte,
  output logic                      adv,
  lsbne_out_if.source               out_ch
);
  import lsbne_pkg::*;

  logic             out_valid_r;
  logic             out_last_r;
  logic [SPI_W-1:0] out_codes_r;
  logic [SPI_W-1:0] codes;

  assign adv = !out_valid_r || out_ch.ready;

  // MSB of the frame byte lands in the top code byte
  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      codes[i*BYTE_W +: BYTE_W] = fbyte.data[i] ? CODE_ONE : CODE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fbyte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_codes_r <= codes;
      out_last_r  <= fbyte.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.spi_codes = out_codes_r;
  assign out_ch.last      = out_last_r;

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the LED strip BCD number encoder.
`timescale 1ns / 1ps
module testbench;
  import lsbne_pkg::*;

  localparam int PIXELS      = 16;
  localparam int WORDS_PER_N = PIXELS * 3;
  localparam int SETTLE      = 20;

  typedef struct packed {
    logic [SPI_W-1:0] spi_codes;
    logic             last;
  } code_word_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  lsbne_in_if  in_ch ();
  lsbne_out_if out_ch ();

  led_strip_bcd_number_encoder #(.PIXEL_COUNT(PIXELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  code_word_t strip_words_q[$];
  code_word_t head_word;
  logic [7:0] brightness_q;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_left;
  int         mismatches;
  int         numbers_sent;
  int         words_checked;
  int         settings_used;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("led_strip_bcd_number_encoder verification failed");
    $finish;
  end

  function automatic logic [SPI_W-1:0] line_codes(input logic [7:0] color_val);
    logic [SPI_W-1:0] acc;
    acc = '0;
    for (int b = 7; b >= 0; b--) begin
      acc = {acc[SPI_W-9:0], color_val[b] ? CODE_ONE : CODE_ZERO};
    end
    return acc;
  endfunction

  function automatic logic [3:0] bcd_digit(input logic [NUM_W-1:0] n, input int idx);
    int unsigned v;
    v = n;
    for (int i = 0; i < idx && i < 8; i++) begin
      v = v / 10;
    end
    return 4'(v % 10);
  endfunction

  // Builds the whole strip for one number and queues its code words.
  function automatic void encode_strip(input logic [NUM_W-1:0] n);
    int         pos;
    int         word_idx;
    logic       upper;
    logic       lit;
    logic [3:0] digit;
    logic [7:0] comp[3];
    word_idx = 0;
    for (int pix = 0; pix < PIXELS; pix++) begin
      pos   = pix % 8;
      upper = (pos >= 4);
      digit = bcd_digit(n, (pix / 8) * 2 + int'(upper));
      lit   = digit[pos % 4];
      if (lit) begin
        comp[0] = upper ? 8'd0 : brightness_q;
        comp[1] = 8'd0;
        comp[2] = upper ? brightness_q : 8'd0;
      end else begin
        comp[0] = upper ? 8'd0 : DIM_LEVEL;
        comp[1] = DIM_LEVEL;
        comp[2] = DIM_LEVEL;
      end
      for (int c = 0; c < 3; c++) begin
        strip_words_q.push_back({line_codes(comp[c]), word_idx == WORDS_PER_N - 1});
        word_idx++;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (strip_words_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item spi_codes=%h last=%b",
                                  out_ch.spi_codes, out_ch.last));
      end else begin
        head_word = strip_words_q.pop_front();
        if (out_ch.spi_codes !== head_word.spi_codes) begin
          report_mismatch($sformatf("spi_codes got %h want %h",
                                    out_ch.spi_codes, head_word.spi_codes));
        end
        if (out_ch.last !== head_word.last) begin
          report_mismatch($sformatf("last got %b want %b", out_ch.last, head_word.last));
        end
        words_checked++;
      end
    end
  end

  // Receiver: random backpressure, or a counted hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_number(input logic [NUM_W-1:0] n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.number = n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_strip(n);
    numbers_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (strip_words_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_brightness(input logic [7:0] level);
    cfg_we    = 1'b1;
    cfg_wdata = level;
    @(negedge clk);
    cfg_we       = 1'b0;
    brightness_q = level;
    settings_used++;
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(0, 3))
      0: return NUM_W'($urandom_range(0, 65535));
      1: return NUM_W'($urandom_range(0, 9999));
      2: return NUM_W'($urandom_range(0, 9) + 10 * $urandom_range(0, 9) +
                       100 * $urandom_range(0, 9) + 1000 * $urandom_range(0, 9) +
                       10000 * $urandom_range(0, 5));
      default: return NUM_W'($urandom_range(60000, 65535));
    endcase
  endfunction

  task automatic test_reset_brightness();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_number(16'd0);
    send_number(16'd65535);
    send_number(16'd9999);
    send_number(16'd8888);
    send_number(16'd10000);
    send_number(16'd1);
    send_number(16'd12345);
    wait_drained();
  endtask

  task automatic test_brightness_levels();
    write_brightness(8'd0);
    send_number(16'd8888);
    send_number(16'd0);
    wait_drained();
    // level 1 makes lit and dim lower pixels look alike on green
    write_brightness(8'd1);
    send_number(16'd9999);
    wait_drained();
    write_brightness(8'h80);
    send_number(16'd4321);
    wait_drained();
    write_brightness(8'($urandom_range(2, 254)));
    send_number(16'd7777);
    wait_drained();
    write_brightness(8'd255);
  endtask

  task automatic test_receiver_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 400;
    repeat (6) send_number(pick_number());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int idle_send[3];
    int idle_recv[3];
    idle_send = '{20, 55, 0};
    idle_recv = '{55, 20, 0};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_send[ph];
      recv_idle_pct = idle_recv[ph];
      write_brightness(8'($urandom_range(0, 255)));
      repeat (30) send_number(pick_number());
      wait_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.number  = '0;
    brightness_q  = 8'd255;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    mismatches    = 0;
    numbers_sent  = 0;
    words_checked = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_brightness();
    test_brightness_levels();
    test_receiver_holdoff();
    test_random_traffic();

    repeat (SETTLE) @(posedge clk);
    if (strip_words_q.size() != 0) begin
      report_mismatch($sformatf("%0d code words never arrived", strip_words_q.size()));
    end
    $display("Sent %0d numbers across %0d brightness writes; %0d code words checked.",
             numbers_sent, settings_used, words_checked);
    $display("Traffic mixed sender gaps, receiver backpressure and a long output hold-off.");
    if (mismatches == 0) begin
      $display("led_strip_bcd_number_encoder verification clean");
    end else begin
      $display("led_strip_bcd_number_encoder verification failed");
    end
    $finish;
  end

endmodule

[led_strip_bcd_number_encoder.f]
rtl/core/lsbne_pkg.sv
rtl/core/lsbne_if.sv
rtl/core/lsbne_digit_conv.sv
rtl/core/lsbne_frame_seq.sv
rtl/core/lsbne_code_expand.sv
rtl/core/led_strip_bcd_number_encoder.sv
dv/testbench.sv
